/* sv/disk_block_bitmap_allocator_macros.svh */
// Assertion macros used by the top-level RTL of the disk block bitmap allocator.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef DISK_BLOCK_BITMAP_ALLOCATOR_MACROS_SVH
`define DISK_BLOCK_BITMAP_ALLOCATOR_MACROS_SVH

// A property that must hold in the same cycle as its condition.
`define DBBA_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// A property that must hold in the cycle after its condition.
`define DBBA_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* sv/dbba_pkg.sv */
// Types, codes and helper functions of the disk block bitmap allocator.
// Used by the top level, the checker and the testbench; depends on nothing else.
package dbba_pkg;

	localparam int BMP_W  = 24;
	localparam int CNT_W  = 8;
	localparam int TRK_W  = 8;
	localparam int SEC_W  = 5;
	localparam int PREF_W = 6;
	localparam int FTRK_W = 6;
	localparam int TOT_W  = 16;
	localparam int OP_W   = 3;
	localparam int STS_W  = 2;

	localparam logic [OP_W-1:0] OP_LOAD       = 3'd0;
	localparam logic [OP_W-1:0] OP_READ       = 3'd1;
	localparam logic [OP_W-1:0] OP_ALLOC_NEAR = 3'd2;
	localparam logic [OP_W-1:0] OP_ALLOC_DIR  = 3'd3;
	localparam logic [OP_W-1:0] OP_ALLOC_AT   = 3'd4;
	localparam logic [OP_W-1:0] OP_FREE_AT    = 3'd5;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

	localparam logic [STS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STS_W-1:0] STS_BAD_TRACK = 2'd1;
	localparam logic [STS_W-1:0] STS_SAME      = 2'd2;
	localparam logic [STS_W-1:0] STS_NONE_FREE = 2'd3;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [BMP_W-1:0] bmp;
	} entry_t;

	typedef struct packed {
		logic             hit;
		logic [SEC_W-1:0] sec;
	} pick_t;

	function automatic logic [SEC_W-1:0] sectors_of(input logic [TRK_W-1:0] t);
		logic [SEC_W-1:0] n;
		if (t <= 8'd17)      n = 5'd21;
		else if (t <= 8'd24) n = 5'd19;
		else if (t <= 8'd30) n = 5'd18;
		else                 n = 5'd17;
		return n;
	endfunction

	// Lowest set bit below n, optionally ignoring sector 0.
	function automatic pick_t first_free(input logic [BMP_W-1:0] bmp,
			input logic [SEC_W-1:0] n, input logic skip0);
		pick_t p;
		p = '0;
		for (int s = BMP_W - 1; s >= 0; s--) begin
			if (bmp[s] && (SEC_W'(s) < n) && !(skip0 && s == 0)) begin
				p.hit = 1'b1;
				p.sec = SEC_W'(s);
			end
		end
		return p;
	endfunction

endpackage

/* sv/dbba_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; holds the per-track map entries of the allocator.
module dbba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 35
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/disk_block_bitmap_allocator.sv */
// Top level of the disk block bitmap allocator: control sequencer and map RAM.
// Depends on dbba_pkg, dbba_ram and disk_block_bitmap_allocator_macros.svh.
//
// The allocator keeps a free bitmap and a free count for each track in a single
// map RAM with a registered read, plus a running free total that leaves out
// the directory track and a dirty flag. It works on one command at a time and
// returns one result beat for each command beat. Load, read, directory allocation,
// allocate-at and free-at step from acceptance through issuing the RAM read,
// modifying and writing back, and handing the result to the output register.
// Clear-dirty, unused and rejected commands go from acceptance straight to the
// hand-over. The nearest-track search reads one candidate track per cycle through
// the RAM read port, alternating above and below the preferred track. A result
// that waits for m_axis_tready holds the block for as long as it waits. Every
// track reads as empty after reset.
`include "disk_block_bitmap_allocator_macros.svh"

module disk_block_bitmap_allocator
	import dbba_pkg::*;
#(
	parameter int NUM_TRACKS      = 35,
	parameter int DIRECTORY_TRACK = 18
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// track[7:0], sector[12:8], start_track[18:13], load_count[26:19],
	// load_bitmap[50:27], zero padding[55:51]
	input  logic [55:0] s_axis_tdata,
	// operation[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// found_track[5:0], found_sector[10:6], free_count[18:11], bitmap[42:19],
	// total_free[58:43], dirty[59], zero padding[63:60]
	output logic [63:0] m_axis_tdata,
	// status[1:0]
	output logic [1:0]  m_axis_tuser
);

	localparam int AW = $clog2(NUM_TRACKS);
	localparam int DW = $clog2(NUM_TRACKS + 1);
	localparam logic [TRK_W-1:0] NUM_T8 = TRK_W'(NUM_TRACKS);
	localparam logic [TRK_W-1:0] DIR_T8 = TRK_W'(DIRECTORY_TRACK);
	localparam logic             DIR_OK = (DIRECTORY_TRACK <= NUM_TRACKS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_EVAL = 3'd2;
	localparam logic [2:0] ST_SRCH = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q, state_d;

	logic [OP_W-1:0]   in_op;
	logic [TRK_W-1:0]  in_trk;
	logic [SEC_W-1:0]  in_sec;
	logic [PREF_W-1:0] in_pref;
	logic [CNT_W-1:0]  in_lcnt;
	logic [BMP_W-1:0]  in_lbmp;
	logic              s_acc;

	logic [OP_W-1:0]   op_q;
	logic [TRK_W-1:0]  trk_q;
	logic [SEC_W-1:0]  sec_q;
	logic [PREF_W-1:0] pref_q;
	logic [CNT_W-1:0]  lcnt_q;
	logic [BMP_W-1:0]  lbmp_q;

	logic [DW-1:0] d_q, d_d;
	logic          dir_q, dir_d;

	logic [NUM_TRACKS-1:0] valid_q;
	logic                  vld_s1;
	logic                  cand_vld_s1;
	logic [TRK_W-1:0]      cand_trk_s1;

	logic             rd_en;
	logic [TRK_W-1:0] rd_trk;
	logic [AW-1:0]    raddr;
	logic             we;
	logic [TRK_W-1:0] wtrk;
	logic [AW-1:0]    waddr;
	entry_t           wentry;
	entry_t           rdata;
	entry_t           ent;

	logic [TOT_W-1:0] tot_q, tot_d;
	logic             dirty_q, dirty_d;

	logic              res_ld;
	logic [STS_W-1:0]  res_sts, res_sts_q;
	logic [FTRK_W-1:0] res_ftrk, res_ftrk_q;
	logic [SEC_W-1:0]  res_fsec, res_fsec_q;
	entry_t            res_ent, res_ent_q;

	logic              out_ld;
	logic [STS_W-1:0]  out_sts_q;
	logic [FTRK_W-1:0] out_ftrk_q;
	logic [SEC_W-1:0]  out_fsec_q;
	entry_t            out_ent_q;
	logic [TOT_W-1:0]  out_tot_q;
	logic              out_dirty_q;

	logic [TRK_W-1:0] plus_t;
	logic [TRK_W-1:0] minus_t;
	logic [TRK_W-1:0] cand_t;
	logic             cand_ok;
	logic             minus_ok;
	logic             stop;
	pick_t            pick;
	logic             sec_bit;
	logic             in_trk_ok;

	assign in_op   = s_axis_tuser;
	assign in_trk  = s_axis_tdata[7:0];
	assign in_sec  = s_axis_tdata[12:8];
	assign in_pref = s_axis_tdata[18:13];
	assign in_lcnt = s_axis_tdata[26:19];
	assign in_lbmp = s_axis_tdata[50:27];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign in_trk_ok     = (in_trk != '0) && (in_trk <= NUM_T8);

	assign ent     = vld_s1 ? rdata : '0;
	assign pick    = first_free(ent.bmp, sectors_of(cand_trk_s1), (op_q == OP_ALLOC_DIR));
	assign sec_bit = ent.bmp[sec_q];

	assign plus_t   = TRK_W'(pref_q) + TRK_W'(d_q);
	assign minus_t  = TRK_W'(pref_q) - TRK_W'(d_q);
	assign cand_t   = dir_q ? minus_t : plus_t;
	assign cand_ok  = (cand_t != '0) && (cand_t <= NUM_T8) && (cand_t != DIR_T8);
	assign minus_ok = (d_q != '0) && (TRK_W'(d_q) < TRK_W'(pref_q));
	assign stop     = !dir_q && ((d_q == DW'(NUM_TRACKS)) ||
		((plus_t > NUM_T8) && (TRK_W'(d_q) >= TRK_W'(pref_q))));

	assign raddr = AW'(rd_trk - 8'd1);
	assign waddr = AW'(wtrk - 8'd1);

	always_comb begin
		state_d  = state_q;
		d_d      = d_q;
		dir_d    = dir_q;
		rd_en    = 1'b0;
		rd_trk   = trk_q;
		we       = 1'b0;
		wtrk     = cand_trk_s1;
		wentry   = ent;
		dirty_d  = dirty_q;
		res_ld   = 1'b0;
		res_sts  = STS_OK;
		res_ftrk = '0;
		res_fsec = '0;
		res_ent  = '0;
		out_ld   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					unique case (in_op)
						OP_LOAD, OP_READ: begin
							if (in_trk_ok) begin
								state_d = ST_READ;
							end else begin
								res_ld  = 1'b1;
								res_sts = STS_BAD_TRACK;
								state_d = ST_OUT;
							end
						end
						OP_ALLOC_AT, OP_FREE_AT: begin
							if (in_trk_ok && in_sec < SEC_W'(BMP_W)) begin
								state_d = ST_READ;
							end else begin
								res_ld  = 1'b1;
								res_sts = STS_BAD_TRACK;
								state_d = ST_OUT;
							end
						end
						OP_ALLOC_NEAR: begin
							d_d     = '0;
							dir_d   = 1'b0;
							state_d = ST_SRCH;
						end
						OP_ALLOC_DIR: begin
							if (DIR_OK) begin
								state_d = ST_READ;
							end else begin
								res_ld  = 1'b1;
								res_sts = STS_BAD_TRACK;
								state_d = ST_OUT;
							end
						end
						OP_CLEAR: begin
							dirty_d = 1'b0;
							res_ld  = 1'b1;
							state_d = ST_OUT;
						end
						default: begin
							res_ld  = 1'b1;
							state_d = ST_OUT;
						end
					endcase
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				rd_trk  = (op_q == OP_ALLOC_DIR) ? DIR_T8 : trk_q;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				res_ld  = 1'b1;
				res_ent = ent;
				state_d = ST_OUT;
				unique case (op_q)
					OP_LOAD: begin
						we      = 1'b1;
						wentry  = '{cnt: lcnt_q, bmp: lbmp_q};
						res_ent = wentry;
					end
					OP_ALLOC_DIR: begin
						if (pick.hit) begin
							we         = 1'b1;
							wentry.bmp = ent.bmp & ~(BMP_W'(1) << pick.sec);
							wentry.cnt = ent.cnt - 8'd1;
							dirty_d    = 1'b1;
							res_ftrk   = cand_trk_s1[FTRK_W-1:0];
							res_fsec   = pick.sec;
							res_ent    = wentry;
						end else begin
							res_sts = STS_NONE_FREE;
							res_ent = '0;
						end
					end
					OP_ALLOC_AT: begin
						if (sec_bit) begin
							we         = 1'b1;
							wentry.bmp = ent.bmp & ~(BMP_W'(1) << sec_q);
							wentry.cnt = ent.cnt - 8'd1;
							dirty_d    = 1'b1;
							res_ent    = wentry;
						end else begin
							res_sts = STS_SAME;
						end
					end
					OP_FREE_AT: begin
						if (!sec_bit) begin
							we         = 1'b1;
							wentry.bmp = ent.bmp | (BMP_W'(1) << sec_q);
							wentry.cnt = ent.cnt + 8'd1;
							dirty_d    = 1'b1;
							res_ent    = wentry;
						end else begin
							res_sts = STS_SAME;
						end
					end
					default: begin
					end
				endcase
			end
			ST_SRCH: begin
				if (cand_vld_s1 && pick.hit) begin
					we         = 1'b1;
					wentry.bmp = ent.bmp & ~(BMP_W'(1) << pick.sec);
					wentry.cnt = ent.cnt - 8'd1;
					dirty_d    = 1'b1;
					res_ld     = 1'b1;
					res_ftrk   = cand_trk_s1[FTRK_W-1:0];
					res_fsec   = pick.sec;
					res_ent    = wentry;
					state_d    = ST_OUT;
				end else if (stop && !cand_vld_s1) begin
					res_ld  = 1'b1;
					res_sts = STS_NONE_FREE;
					state_d = ST_OUT;
				end else if (!stop) begin
					rd_en  = cand_ok;
					rd_trk = cand_t;
					if (!dir_q && minus_ok) begin
						dir_d = 1'b1;
					end else begin
						dir_d = 1'b0;
						d_d   = d_q + DW'(1);
					end
				end
			end
			ST_OUT: begin
				if (!m_axis_tvalid || m_axis_tready) begin
					out_ld  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		tot_d = tot_q;
		if (we && wtrk != DIR_T8) begin
			tot_d = tot_q - TOT_W'(ent.cnt) + TOT_W'(wentry.cnt);
		end
	end

	dbba_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(NUM_TRACKS)
	) u_map_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wentry),
		.re   (rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			d_q           <= '0;
			dir_q         <= 1'b0;
			valid_q       <= '0;
			vld_s1        <= 1'b0;
			cand_vld_s1   <= 1'b0;
			tot_q         <= '0;
			dirty_q       <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q     <= state_d;
			d_q         <= d_d;
			dir_q       <= dir_d;
			cand_vld_s1 <= rd_en;
			vld_s1      <= rd_en && valid_q[raddr];
			tot_q       <= tot_d;
			dirty_q     <= dirty_d;
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (out_ld) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q   <= in_op;
			trk_q  <= in_trk;
			sec_q  <= in_sec;
			pref_q <= in_pref;
			lcnt_q <= in_lcnt;
			lbmp_q <= in_lbmp;
		end
		if (rd_en) begin
			cand_trk_s1 <= rd_trk;
		end
		if (res_ld) begin
			res_sts_q  <= res_sts;
			res_ftrk_q <= res_ftrk;
			res_fsec_q <= res_fsec;
			res_ent_q  <= res_ent;
		end
		if (out_ld) begin
			out_sts_q   <= res_sts_q;
			out_ftrk_q  <= res_ftrk_q;
			out_fsec_q  <= res_fsec_q;
			out_ent_q   <= res_ent_q;
			out_tot_q   <= tot_q;
			out_dirty_q <= dirty_q;
		end
	end

	assign m_axis_tuser = out_sts_q;
	assign m_axis_tdata = {4'b0, out_dirty_q, out_tot_q, out_ent_q.bmp, out_ent_q.cnt,
		out_fsec_q, out_ftrk_q};

	`DBBA_ASSERT_NOW(a_write_state, we, (state_q == ST_EVAL || state_q == ST_SRCH), "map write outside update")
	`DBBA_ASSERT_NOW(a_search_skips_dir, (we && state_q == ST_SRCH), (wtrk != DIR_T8), "search took directory track")
	`DBBA_ASSERT_NOW(a_search_bound, (state_q == ST_SRCH), (d_q <= DW'(NUM_TRACKS)), "search ran past last distance")
	`DBBA_ASSERT_NOW(a_result_source, $rose(m_axis_tvalid), ($past(state_q) == ST_OUT), "result beat without hand-over")
	`DBBA_ASSERT_NEXT(a_read_then_eval, (state_q == ST_READ), (state_q == ST_EVAL && cand_vld_s1), "read not followed by update")

endmodule

/* dv/dbba_checker.sv */
// Result checker for the disk block bitmap allocator: watches both stream channels,
// keeps its own copy of the track map and compares every result beat with it.
// Depends on dbba_pkg for widths and for the operation and status codes.
`timescale 1ns / 100ps

module dbba_checker
	import dbba_pkg::*;
#(
	parameter int NUM_TRACKS      = 35,
	parameter int DIRECTORY_TRACK = 18
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,
	input  logic [2:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [STS_W-1:0]  status;
		logic [FTRK_W-1:0] ftrk;
		logic [SEC_W-1:0]  fsec;
		logic [CNT_W-1:0]  cnt;
		logic [BMP_W-1:0]  bmp;
		logic [TOT_W-1:0]  total;
		logic              dirty;
	} outcome_t;

	logic [BMP_W-1:0] free_map [1:NUM_TRACKS];
	logic [CNT_W-1:0] free_cnt [1:NUM_TRACKS];
	logic             map_changed;
	outcome_t         awaited_q [$];

	function automatic int sectors_in(int t);
		if (t >= 31) return 17;
		if (t >= 25) return 18;
		if (t >= 18) return 19;
		return 21;
	endfunction

	function automatic bit track_exists(int t);
		return t >= 1 && t <= NUM_TRACKS;
	endfunction

	function automatic int lowest_free(int t, int from);
		for (int s = from; s < sectors_in(t); s++)
			if (free_map[t][s]) return s;
		return -1;
	endfunction

	function automatic void claim(int t, int s);
		free_map[t][s] = 1'b0;
		free_cnt[t] = free_cnt[t] - CNT_W'(1);
		map_changed = 1'b1;
	endfunction

	function automatic outcome_t apply_command(logic [OP_W-1:0] op, logic [TRK_W-1:0] trk,
			logic [SEC_W-1:0] sec, logic [PREF_W-1:0] pref, logic [CNT_W-1:0] lcnt,
			logic [BMP_W-1:0] lbmp);
		outcome_t r;
		int shown, t, s, sum;
		r = '0;
		shown = 0;
		s = -1;
		sum = 0;
		case (op)
		OP_LOAD, OP_READ: begin
			if (!track_exists(int'(trk))) begin
				r.status = STS_BAD_TRACK;
			end else begin
				if (op == OP_LOAD) begin
					free_map[trk] = lbmp;
					free_cnt[trk] = lcnt;
				end
				shown = int'(trk);
			end
		end
		OP_ALLOC_NEAR: begin
			r.status = STS_NONE_FREE;
			for (int d = 0; d < NUM_TRACKS && s < 0; d++) begin
				for (int side = 0; side < 2 && s < 0; side++) begin
					if (side == 1 && (d == 0 || d > int'(pref))) continue;
					t = (side == 0) ? int'(pref) + d : int'(pref) - d;
					if (!track_exists(t) || t == DIRECTORY_TRACK) continue;
					s = lowest_free(t, 0);
					if (s >= 0) begin
						claim(t, s);
						r.status = STS_OK;
						r.ftrk = FTRK_W'(t);
						r.fsec = SEC_W'(s);
						shown = t;
					end
				end
			end
		end
		OP_ALLOC_DIR: begin
			if (!track_exists(DIRECTORY_TRACK)) begin
				r.status = STS_BAD_TRACK;
			end else begin
				s = lowest_free(DIRECTORY_TRACK, 1);
				if (s < 0) begin
					r.status = STS_NONE_FREE;
				end else begin
					claim(DIRECTORY_TRACK, s);
					r.ftrk = FTRK_W'(DIRECTORY_TRACK);
					r.fsec = SEC_W'(s);
					shown = DIRECTORY_TRACK;
				end
			end
		end
		OP_ALLOC_AT, OP_FREE_AT: begin
			if (!track_exists(int'(trk)) || int'(sec) >= BMP_W) begin
				r.status = STS_BAD_TRACK;
			end else begin
				shown = int'(trk);
				if (op == OP_ALLOC_AT) begin
					if (!free_map[trk][sec]) r.status = STS_SAME;
					else claim(int'(trk), int'(sec));
				end else if (free_map[trk][sec]) begin
					r.status = STS_SAME;
				end else begin
					free_map[trk][sec] = 1'b1;
					free_cnt[trk] = free_cnt[trk] + CNT_W'(1);
					map_changed = 1'b1;
				end
			end
		end
		OP_CLEAR: map_changed = 1'b0;
		default: ;
		endcase
		for (int i = 1; i <= NUM_TRACKS; i++)
			if (i != DIRECTORY_TRACK) sum += int'(free_cnt[i]);
		r.total = TOT_W'(sum);
		if (shown != 0) begin
			r.cnt = free_cnt[shown];
			r.bmp = free_map[shown];
		end
		r.dirty = map_changed;
		return r;
	endfunction

	task automatic compare_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want, got;
		if (!arst_n) begin
			for (int i = 1; i <= NUM_TRACKS; i++) begin
				free_map[i] = '0;
				free_cnt[i] = '0;
			end
			map_changed = 1'b0;
			awaited_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = m_axis_tuser;
				got.ftrk   = m_axis_tdata[5:0];
				got.fsec   = m_axis_tdata[10:6];
				got.cnt    = m_axis_tdata[18:11];
				got.bmp    = m_axis_tdata[42:19];
				got.total  = m_axis_tdata[58:43];
				got.dirty  = m_axis_tdata[59];
				if (awaited_q.size() == 0) begin
					$display("%0t: result beat with none expected, expected nothing, got %h/%h",
						$time, m_axis_tuser, m_axis_tdata);
					errors++;
				end else begin
					want = awaited_q.pop_front();
					compare_field("status", longint'(want.status), longint'(got.status));
					compare_field("found_track", longint'(want.ftrk), longint'(got.ftrk));
					compare_field("found_sector", longint'(want.fsec), longint'(got.fsec));
					compare_field("free_count", longint'(want.cnt), longint'(got.cnt));
					compare_field("bitmap", longint'(want.bmp), longint'(got.bmp));
					compare_field("total_free", longint'(want.total), longint'(got.total));
					compare_field("dirty", longint'(want.dirty), longint'(got.dirty));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				awaited_q.push_back(apply_command(s_axis_tuser, s_axis_tdata[7:0],
					s_axis_tdata[12:8], s_axis_tdata[18:13], s_axis_tdata[26:19],
					s_axis_tdata[50:27]));
			pending = awaited_q.size();
		end
	end

endmodule

/* dv/disk_block_bitmap_allocator_tb.sv */
// Testbench top of the disk block bitmap allocator: clock, reset, command stimulus
// with random gaps and result back-pressure, and the final verdict.
// Depends on dbba_pkg, the allocator RTL and dbba_checker.
`timescale 1ns / 100ps

module disk_block_bitmap_allocator_tb
	import dbba_pkg::*;
();

	localparam int NUM_TRACKS      = 35;
	localparam int DIRECTORY_TRACK = 18;
	localparam int RANDOM_CMDS     = 1600;
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	int          errors;
	int          pending;
	bit          steady;

	disk_block_bitmap_allocator #(
		.NUM_TRACKS      (NUM_TRACKS),
		.DIRECTORY_TRACK (DIRECTORY_TRACK)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	dbba_checker #(
		.NUM_TRACKS      (NUM_TRACKS),
		.DIRECTORY_TRACK (DIRECTORY_TRACK)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.errors        (errors),
		.pending       (pending)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 17);
			@(negedge clk);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	task automatic send_cmd(logic [OP_W-1:0] op, logic [TRK_W-1:0] trk,
			logic [SEC_W-1:0] sec, logic [PREF_W-1:0] pref, logic [CNT_W-1:0] lcnt,
			logic [BMP_W-1:0] lbmp);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 17);
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {5'b0, lbmp, lcnt, pref, sec, trk};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Draining phases hold back loads and most frees so that the map runs dry.
	task automatic random_cmd(bit draining);
		logic [OP_W-1:0]   op;
		logic [TRK_W-1:0]  trk;
		logic [SEC_W-1:0]  sec;
		logic [PREF_W-1:0] pref;
		logic [CNT_W-1:0]  lcnt;
		logic [BMP_W-1:0]  lbmp;
		int pick;
		trk  = TRK_W'($urandom);
		sec  = SEC_W'($urandom);
		pref = PREF_W'($urandom);
		lcnt = CNT_W'($urandom);
		lbmp = BMP_W'($urandom);
		pick = $urandom_range(0, 99);
		if (draining && (pick < 15 || (pick >= 60 && pick < 85))) pick = 30;
		if (pick < 15)      op = OP_LOAD;
		else if (pick < 25) op = OP_READ;
		else if (pick < 50) op = OP_ALLOC_NEAR;
		else if (pick < 58) op = OP_ALLOC_DIR;
		else if (pick < 73) op = OP_ALLOC_AT;
		else if (pick < 88) op = OP_FREE_AT;
		else if (pick < 96) op = OP_CLEAR;
		else                op = OP_UNUSED;
		if ($urandom_range(0, 9) != 0) trk = TRK_W'($urandom_range(1, NUM_TRACKS));
		if (op == OP_LOAD && $urandom_range(0, 9) == 0) trk = TRK_W'(DIRECTORY_TRACK);
		if ($urandom_range(0, 9) != 0) sec = SEC_W'($urandom_range(0, BMP_W - 1));
		if ($urandom_range(0, 9) != 0) pref = PREF_W'($urandom_range(0, NUM_TRACKS));
		case ($urandom_range(0, 3))
		0: lbmp = 24'h1FFFFF >> $urandom_range(0, 4);
		1: lbmp = 24'hFFFFFF;
		2: lbmp = 24'h1 << $urandom_range(0, BMP_W - 1);
		default: ;
		endcase
		if ($urandom_range(0, 9) < 7) lcnt = CNT_W'($countones(lbmp));
		send_cmd(op, trk, sec, pref, lcnt, lbmp);
	endtask

	initial begin
		arst_n        = 1'b0;
		steady        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_READ;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		send_cmd(OP_READ, 8'd1, 5'd0, 6'd0, 8'd0, 24'h0);
		send_cmd(OP_READ, 8'd0, 5'd0, 6'd0, 8'd0, 24'h0);
		send_cmd(OP_LOAD, 8'd255, 5'd0, 6'd0, 8'd7, 24'h7);
		send_cmd(OP_ALLOC_NEAR, 8'd0, 5'd0, 6'd1, 8'd0, 24'h0);
		send_cmd(OP_ALLOC_DIR, 8'd0, 5'd0, 6'd0, 8'd0, 24'h0);
		send_cmd(OP_LOAD, 8'd1, 5'd0, 6'd0, 8'd255, 24'hFFFFFF);
		send_cmd(OP_LOAD, 8'd35, 5'd0, 6'd0, 8'd1, 24'h100000);
		send_cmd(OP_ALLOC_NEAR, 8'd0, 5'd0, 6'd35, 8'd0, 24'h0);
		send_cmd(OP_LOAD, 8'd18, 5'd0, 6'd0, 8'd1, 24'h000001);
		send_cmd(OP_ALLOC_DIR, 8'd0, 5'd0, 6'd0, 8'd0, 24'h0);
		send_cmd(OP_LOAD, 8'd18, 5'd0, 6'd0, 8'd3, 24'h040006);
		send_cmd(OP_ALLOC_DIR, 8'd0, 5'd0, 6'd0, 8'd0, 24'h0);
		send_cmd(OP_ALLOC_NEAR, 8'd0, 5'd0, 6'd18, 8'd0, 24'h0);
		send_cmd(OP_ALLOC_NEAR, 8'd0, 5'd0, 6'd63, 8'd0, 24'h0);
		send_cmd(OP_ALLOC_NEAR, 8'd0, 5'd0, 6'd0, 8'd0, 24'h0);
		send_cmd(OP_ALLOC_AT, 8'd1, 5'd23, 6'd0, 8'd0, 24'h0);
		send_cmd(OP_ALLOC_AT, 8'd1, 5'd23, 6'd0, 8'd0, 24'h0);
		send_cmd(OP_FREE_AT, 8'd1, 5'd23, 6'd0, 8'd0, 24'h0);
		send_cmd(OP_FREE_AT, 8'd1, 5'd23, 6'd0, 8'd0, 24'h0);
		send_cmd(OP_ALLOC_AT, 8'd1, 5'd24, 6'd0, 8'd0, 24'h0);
		send_cmd(OP_FREE_AT, 8'd36, 5'd0, 6'd0, 8'd0, 24'h0);
		send_cmd(OP_LOAD, 8'd2, 5'd0, 6'd0, 8'd0, 24'h000001);
		send_cmd(OP_ALLOC_AT, 8'd2, 5'd0, 6'd0, 8'd0, 24'h0);
		send_cmd(OP_CLEAR, 8'd0, 5'd0, 6'd0, 8'd0, 24'h0);
		send_cmd(OP_UNUSED, 8'd255, 5'd31, 6'd63, 8'd255, 24'hFFFFFF);

		for (int i = 0; i < RANDOM_CMDS; i++) begin
			steady = (i % 300) >= 240;
			random_cmd((i % 400) >= 250 && (i % 400) < 330);
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (2 * NUM_TRACKS + 10) @(negedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* disk_block_bitmap_allocator.f */
+incdir+sv
sv/dbba_pkg.sv
sv/dbba_ram.sv
sv/disk_block_bitmap_allocator.sv
dv/dbba_checker.sv
dv/disk_block_bitmap_allocator_tb.sv
